>>> hdl/brace_frame_decimal_parser_top_defines.svh
// Assertion macros shared by the brace frame parser modules.
`ifndef BRACE_FRAME_DECIMAL_PARSER_TOP_DEFINES_SVH
`define BRACE_FRAME_DECIMAL_PARSER_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define BFDP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define BFDP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BFDP_ASSERT(lbl, prop, msg)
`define BFDP_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> hdl/bfdp_pkg.sv
// Types, constants and decode helpers for the brace frame decimal parser.
package bfdp_pkg;

  localparam int NUM_FIELDS_DEF  = 5;
  localparam int FIELD_CHARS_DEF = 3;
  localparam int NUM_VALUES      = 4;
  localparam int DECODE_FIELDS   = NUM_VALUES + 1;
  localparam int MAX_CHARS       = 3;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [7:0] CHAR_OPEN  = 8'h7B;
  localparam logic [7:0] CHAR_CLOSE = 8'h7D;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_O     = 8'h4F;
  localparam logic [7:0] CHAR_K     = 8'h4B;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_V     = 8'h56;
  localparam logic [7:0] CHAR_A     = 8'h41;
  localparam logic [7:0] CHAR_R     = 8'h52;
  localparam logic [7:0] DIGIT_ZERO = 8'h30;
  localparam logic [7:0] DIGIT_NINE = 8'h39;
  localparam logic [7:0] MUL_HUNDRED = 8'd100;
  localparam logic [7:0] MUL_TEN     = 8'd10;

  localparam logic [3:0] ACK_O    = 4'h1;
  localparam logic [3:0] ACK_K    = 4'h2;
  localparam logic [3:0] ACK_CR   = 4'h4;
  localparam logic [3:0] ACK_LF   = 4'h8;
  localparam logic [3:0] ACK_ALL  = 4'hF;
  localparam logic [3:0] ACK_NONE = 4'h0;

  typedef enum logic [2:0] {
    CLS_OPEN,
    CLS_CLOSE,
    CLS_SEP,
    CLS_ACK_O,
    CLS_ACK_K,
    CLS_ACK_CR,
    CLS_ACK_LF,
    CLS_OTHER
  } char_class_t;

  typedef struct packed {
    char_class_t cls;
    logic [7:0]  ch;
  } char_op_t;

  function automatic logic is_digit(input logic [7:0] x);
    return (x >= DIGIT_ZERO) && (x <= DIGIT_NINE);
  endfunction

  // Convert up to three ASCII digits, wrapping mod 256; keep prev if none.
  function automatic logic [7:0] decode_field(input logic [7:0] c0, input logic [7:0] c1,
                                              input logic [7:0] c2, input logic [7:0] prev);
    logic [7:0] d0;
    logic [7:0] d1;
    logic [7:0] d2;
    logic [7:0] p0;
    logic [7:0] p1;
    logic [7:0] t0;
    logic [7:0] res;
    d0 = c0 - DIGIT_ZERO;
    d1 = c1 - DIGIT_ZERO;
    d2 = c2 - DIGIT_ZERO;
    p0 = d0 * MUL_HUNDRED;
    p1 = d1 * MUL_TEN;
    t0 = d0 * MUL_TEN;
    if (is_digit(c2)) begin
      res = p0 + p1 + d2;
    end else if (is_digit(c1)) begin
      res = t0 + d1;
    end else if (is_digit(c0)) begin
      res = d0;
    end else begin
      res = prev;
    end
    return res;
  endfunction

endpackage

>>> hdl/bfdp_front.sv
// Front end: accepts characters and classifies them for the back end.
module bfdp_front import bfdp_pkg::*; (
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char,
  input  logic       q_full,
  output logic       q_push,
  output char_op_t   q_op
);

  char_class_t cls;

  always_comb begin
    case (in_char)
      CHAR_OPEN:  cls = CLS_OPEN;
      CHAR_CLOSE: cls = CLS_CLOSE;
      CHAR_COLON: cls = CLS_SEP;
      CHAR_COMMA: cls = CLS_SEP;
      CHAR_O:     cls = CLS_ACK_O;
      CHAR_K:     cls = CLS_ACK_K;
      CHAR_CR:    cls = CLS_ACK_CR;
      CHAR_LF:    cls = CLS_ACK_LF;
      default:    cls = CLS_OTHER;
    endcase
  end

  // Hold off the sender while the queue is full.
  assign in_stall  = q_full;
  assign q_push    = in_valid && !q_full;
  assign q_op.cls  = cls;
  assign q_op.ch   = in_char;

endmodule

>>> hdl/bfdp_queue.sv
// Short queue of classified characters between front and back end.
`include "brace_frame_decimal_parser_top_defines.svh"
module bfdp_queue import bfdp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  char_op_t push_op,
  input  logic     pop,
  output char_op_t head,
  output logic     full,
  output logic     empty
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  char_op_t         entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == FULL_CNT);
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `BFDP_ASSERT(a_no_overflow, push |-> !full, "queue push while full")
  `BFDP_ASSERT(a_no_underflow, pop |-> !empty, "queue pop while empty")
  `BFDP_ASSERT_ALWAYS(a_count_range, rst || count <= FULL_CNT, "queue count out of range")

endmodule

>>> hdl/bfdp_back.sv
// Back end: frame state, field store, decimal decode and result register.
`include "brace_frame_decimal_parser_top_defines.svh"
module bfdp_back import bfdp_pkg::*; #(
  parameter int NUM_FIELDS  = NUM_FIELDS_DEF,
  parameter int FIELD_CHARS = FIELD_CHARS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_empty,
  input  char_op_t   q_head,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       values_valid,
  output logic [7:0] value_a,
  output logic [7:0] value_b,
  output logic [7:0] value_c,
  output logic [7:0] value_d,
  output logic       ack_seen
);

  localparam int FPOS_W = (NUM_FIELDS > 1) ? $clog2(NUM_FIELDS) : 1;
  localparam int CPOS_W = $clog2(FIELD_CHARS + 1);
  localparam logic [FPOS_W-1:0] LAST_FIELD = FPOS_W'(NUM_FIELDS - 1);
  localparam logic [CPOS_W-1:0] CHAR_LIMIT = CPOS_W'(FIELD_CHARS);

  logic [7:0]        field_store [NUM_FIELDS][FIELD_CHARS];
  logic [7:0]        view        [DECODE_FIELDS][MAX_CHARS];
  logic [7:0]        values      [NUM_VALUES];
  logic [7:0]        values_next [NUM_VALUES];
  logic [FPOS_W-1:0] field_pos;
  logic [FPOS_W-1:0] field_pos_next;
  logic [CPOS_W-1:0] char_pos;
  logic [CPOS_W-1:0] char_pos_next;
  logic              in_frame;
  logic              in_frame_next;
  logic [3:0]        ack_bits;
  logic [3:0]        ack_bits_next;
  logic [3:0]        ack_upd;
  logic              store_we;
  logic              store_clr;
  logic              emit_valid;
  logic              emit_ack;
  logic              var_match;

  // Fixed read view of the store; missing positions read as zero.
  for (genvar f = 0; f < DECODE_FIELDS; f++) begin : g_vf
    for (genvar k = 0; k < MAX_CHARS; k++) begin : g_vk
      if (f < NUM_FIELDS && k < FIELD_CHARS) begin : g_in
        assign view[f][k] = field_store[f][k];
      end else begin : g_out
        assign view[f][k] = '0;
      end
    end
  end

  assign var_match = (view[0][0] == CHAR_V) && (view[0][1] == CHAR_A) &&
                     (view[0][2] == CHAR_R);

  // Advance when a result slot is free or the pending one is taken.
  assign q_pop = !q_empty && (!out_valid || !out_stall);

  always_comb begin
    in_frame_next  = in_frame;
    field_pos_next = field_pos;
    char_pos_next  = char_pos;
    ack_upd        = ack_bits;
    store_we       = 1'b0;
    store_clr      = 1'b0;
    emit_valid     = 1'b0;
    emit_ack       = 1'b0;
    for (int j = 0; j < NUM_VALUES; j++) begin
      values_next[j] = values[j];
    end
    case (q_head.cls)
      CLS_OPEN: begin
        in_frame_next  = 1'b1;
        field_pos_next = '0;
        char_pos_next  = '0;
      end
      CLS_CLOSE: begin
        in_frame_next = 1'b0;
        if (var_match) begin
          for (int j = 0; j < NUM_VALUES; j++) begin
            values_next[j] = decode_field(view[j+1][0], view[j+1][1], view[j+1][2],
                                          values[j]);
          end
          store_clr  = 1'b1;
          emit_valid = 1'b1;
        end
      end
      CLS_SEP: begin
        if (field_pos != LAST_FIELD) begin
          field_pos_next = field_pos + 1'b1;
        end
        char_pos_next = '0;
      end
      default: begin
        if (in_frame) begin
          if (char_pos != CHAR_LIMIT) begin
            store_we      = 1'b1;
            char_pos_next = char_pos + 1'b1;
          end
        end else begin
          case (q_head.cls)
            CLS_ACK_O:  ack_upd = ACK_O;
            CLS_ACK_K:  ack_upd = ack_bits | ACK_K;
            CLS_ACK_CR: ack_upd = ack_bits | ACK_CR;
            CLS_ACK_LF: ack_upd = ack_bits | ACK_LF;
            default:    ack_upd = ack_bits;
          endcase
        end
      end
    endcase
    ack_bits_next = ack_upd;
    if (ack_upd == ACK_ALL) begin
      emit_ack      = 1'b1;
      ack_bits_next = ACK_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame     <= 1'b0;
      field_pos    <= '0;
      char_pos     <= '0;
      ack_bits     <= ACK_NONE;
      out_valid    <= 1'b0;
      values_valid <= 1'b0;
      ack_seen     <= 1'b0;
      for (int j = 0; j < NUM_VALUES; j++) begin
        values[j] <= '0;
      end
      for (int f = 0; f < NUM_FIELDS; f++) begin
        for (int k = 0; k < FIELD_CHARS; k++) begin
          field_store[f][k] <= '0;
        end
      end
    end else begin
      if (q_pop) begin
        in_frame     <= in_frame_next;
        field_pos    <= field_pos_next;
        char_pos     <= char_pos_next;
        ack_bits     <= ack_bits_next;
        out_valid    <= 1'b1;
        values_valid <= emit_valid;
        ack_seen     <= emit_ack;
        for (int j = 0; j < NUM_VALUES; j++) begin
          values[j] <= values_next[j];
        end
        for (int f = 0; f < NUM_FIELDS; f++) begin
          for (int k = 0; k < FIELD_CHARS; k++) begin
            if (store_clr) begin
              field_store[f][k] <= '0;
            end else if (store_we && field_pos == FPOS_W'(f) && char_pos == CPOS_W'(k)) begin
              field_store[f][k] <= q_head.ch;
            end
          end
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign value_a = values[0];
  assign value_b = values[1];
  assign value_c = values[2];
  assign value_d = values[3];

  `BFDP_ASSERT(a_ack_never_full, ack_bits != ACK_ALL, "ack bits left at all set")
  `BFDP_ASSERT(a_field_sat, field_pos <= LAST_FIELD, "field index past last field")
  `BFDP_ASSERT(a_char_sat, char_pos <= CHAR_LIMIT, "char index past field width")
  `BFDP_ASSERT(a_excl_result, !(values_valid && ack_seen), "frame and ack in one result")
  `BFDP_ASSERT(a_open_frame, (q_pop && q_head.cls == CLS_OPEN) |=> in_frame,
               "open brace did not enter frame")

endmodule

>>> hdl/brace_frame_decimal_parser_top.sv
// Top level of the brace frame decimal parser.
//
//  channel | valid     | stall      | payload
//  --------+-----------+------------+----------------------------------------------
//  input   | in_valid  | in_stall   | in_char
//  output  | out_valid | out_stall  | values_valid, value_a..value_d, ack_seen
//
// One character per cycle sustained while out_stall is low; a character's result
// passes through a queue entry and then the result register.
// Each character produces exactly one output transaction.
// rst is synchronous and active high; it clears frame state, the field store
// and the decoded values to zero, and empties the queue.
// An output stall holds the result; the two-entry queue absorbs the input
// until it fills, then in_stall rises.
module brace_frame_decimal_parser_top import bfdp_pkg::*; #(
  parameter int NUM_FIELDS  = NUM_FIELDS_DEF,
  parameter int FIELD_CHARS = FIELD_CHARS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       values_valid,
  output logic [7:0] value_a,
  output logic [7:0] value_b,
  output logic [7:0] value_c,
  output logic [7:0] value_d,
  output logic       ack_seen
);

  // Classified character on its way from front to back.
  char_op_t push_op;
  char_op_t head_op;
  logic     q_push;
  logic     q_pop;
  logic     q_full;
  logic     q_empty;

  // Front: classify the character and push it while the queue has room.
  bfdp_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_char  (in_char),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_op     (push_op)
  );

  // Queue: decouple input acceptance from result stalls.
  bfdp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_op (push_op),
    .pop     (q_pop),
    .head    (head_op),
    .full    (q_full),
    .empty   (q_empty)
  );

  // Back: apply the character to frame state and register the result.
  bfdp_back #(
    .NUM_FIELDS  (NUM_FIELDS),
    .FIELD_CHARS (FIELD_CHARS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_head       (head_op),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .values_valid (values_valid),
    .value_a      (value_a),
    .value_b      (value_b),
    .value_c      (value_c),
    .value_d      (value_d),
    .ack_seen     (ack_seen)
  );

endmodule
